@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/lce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lce_pkg;

	// Field widths
	localparam int COMP_W  = 8;
	localparam int CFG_W   = 12;
	localparam int THR_W   = 8;
	localparam int ERR_W   = 11;
	localparam int SUM_W   = 32;
	localparam int IDX_W   = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_DARK_THRESHOLD = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST    = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST   = 12'd480;
	localparam logic [THR_W-1:0] DARK_THRESHOLD_RST = 8'd100;

	// BT.601 fixed-point gray weights, Q14
	localparam int               WEIGHT_W   = 14;
	localparam int               GRAY_ACC_W = 22;
	localparam logic [WEIGHT_W-1:0]   W_RED      = 14'd4899;
	localparam logic [WEIGHT_W-1:0]   W_GREEN    = 14'd9617;
	localparam logic [WEIGHT_W-1:0]   W_BLUE     = 14'd1868;
	localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND = 22'd8192;
	localparam int               GRAY_SHIFT = 14;

	typedef struct packed {
		logic [COMP_W-1:0] blue;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] red;
		logic              last_in_frame;
	} pixel_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] line_error;
		logic                    line_found;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [CFG_W-1:0] data;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

@@ rtl/lce_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lce_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/lce_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
module lce_div #(
	parameter int DVS_W = 23
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lce_pkg::SUM_W-1:0] dividend,
	input  wire logic [DVS_W-1:0]          divisor,
	output      logic [lce_pkg::SUM_W-1:0] quotient,
	output      lce_pkg::div_stat_t        stat
);
	localparam int CNT_W = $clog2(lce_pkg::SUM_W);

	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [lce_pkg::SUM_W-1:0] quo_q;
	logic [DVS_W-1:0]          rem_q;
	logic [DVS_W-1:0]          dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W+1:0] diff;
	logic             q_bit;
	logic [DVS_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[lce_pkg::SUM_W-1]};
		diff     = {1'b0, trial} - {2'b00, dvs_q};
		q_bit    = ~diff[DVS_W+1];
		// remainder always stays below the divisor
		rem_next = q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(lce_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[lce_pkg::SUM_W-2:0], q_bit};
			rem_q <= rem_next;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

`default_nettype wire

@@ rtl/line_centroid_error_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Dark-line centroid tracker over the bottom quarter band of a frame.
// pixel  (sink):   BGR pixels in raster order plus last_in_frame; column and row
//                  are counted inside, the band is rows floor(3H/4) .. +floor(H/4).
// result (source): one transaction per frame on the pixel flagged last_in_frame:
//                  line_error = floor(column sum / dark count) - floor(W/2),
//                  line_found = 0 with line_error = 0 if nothing was dark.
// cfg    (sink):   register writes, always ready; 0 width, 1 height, 2 threshold.
//                  Write only while the block is idle.
// Per pixel: accept, three multiply-accumulate steps on the one 8x14 multiplier
//   forming the gray level, then the compare/update step; only then is the next pixel taken.
// Frame-end pixel: the result passes through the 32-step radix-2 divider, which
//   is skipped when no pixel was dark.
// Reset: registers return to 640 x 480, threshold 100; counters clear.
// Stall: the result sits in an output register; the next pixel is still taken
//   while it waits, only a second frame result holds the sequencer until the
//   first transaction is taken.
`include "assert_macros.svh"

module line_centroid_error_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input wire logic clk,
	input wire logic arst_n,
	lce_stream_if.sink   pixel,
	lce_stream_if.source result,
	lce_stream_if.sink   cfg
);
	localparam int CW    = $clog2(MAX_WIDTH);         // column counter
	localparam int RW    = $clog2(MAX_HEIGHT);        // row counter
	localparam int WW    = $clog2(MAX_WIDTH + 1);     // effective width
	localparam int HW    = $clog2(MAX_HEIGHT + 1);    // effective height
	localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int EXT_W = (WW > HW ? WW : HW) > lce_pkg::CFG_W ?
	                       (WW > HW ? WW : HW) : lce_pkg::CFG_W;

	typedef enum logic [2:0] {S_IDLE, S_MAC, S_UPD, S_DIV, S_OUT} state_t;

	state_t                             state_q;
	logic [1:0]                         step_q;
	lce_pkg::pixel_t                    px_q;
	logic [lce_pkg::GRAY_ACC_W-1:0]     acc_q;
	logic [CW-1:0]                      col_q;
	logic [RW-1:0]                      row_q;
	logic [TOT_W-1:0]                   total_q;
	logic [lce_pkg::SUM_W-1:0]          sum_q;
	lce_pkg::result_t                   res_q;
	lce_pkg::result_t                   out_q;
	logic                               out_valid_q;

	logic [lce_pkg::CFG_W-1:0]          fw_q;
	logic [lce_pkg::CFG_W-1:0]          fh_q;
	logic [lce_pkg::THR_W-1:0]          thr_q;

	// --- effective frame size, clamped ---
	logic [EXT_W-1:0] fw_ext, fh_ext;
	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;

	always_comb begin
		fw_ext = EXT_W'(fw_q);
		fh_ext = EXT_W'(fh_q);
		if (fw_ext < EXT_W'(2))              w_eff = WW'(2);
		else if (fw_ext > EXT_W'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else                                 w_eff = WW'(fw_ext);
		if (fh_ext < EXT_W'(4))               h_eff = HW'(4);
		else if (fh_ext > EXT_W'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else                                  h_eff = HW'(fh_ext);
	end

	// --- band limits ---
	logic [HW+1:0] h_x3;
	logic [HW-1:0] band_start, band_end;
	logic          in_band;

	always_comb begin
		h_x3       = {2'b00, h_eff} + {1'b0, h_eff, 1'b0};
		band_start = h_x3[HW+1:2];
		band_end   = band_start + (h_eff >> 2);
		in_band    = (HW'(row_q) >= band_start) && (HW'(row_q) < band_end);
	end

	// --- shared gray multiply-accumulate ---
	logic [lce_pkg::COMP_W-1:0]     mul_a;
	logic [lce_pkg::WEIGHT_W-1:0]   mul_b;
	logic [lce_pkg::GRAY_ACC_W-1:0] prod, acc_base, acc_next;

	always_comb begin
		case (step_q)
			2'd0:    begin mul_a = px_q.red;   mul_b = lce_pkg::W_RED;   end
			2'd1:    begin mul_a = px_q.green; mul_b = lce_pkg::W_GREEN; end
			default: begin mul_a = px_q.blue;  mul_b = lce_pkg::W_BLUE;  end
		endcase
		prod     = lce_pkg::GRAY_ACC_W'(mul_a) * lce_pkg::GRAY_ACC_W'(mul_b);
		acc_base = (step_q == 2'd0) ? lce_pkg::GRAY_ROUND : acc_q;
		acc_next = acc_base + prod;
	end

	// --- update step ---
	logic [lce_pkg::THR_W-1:0] gray;
	logic                      hit;
	logic [TOT_W-1:0]          total_new;
	logic [lce_pkg::SUM_W-1:0] sum_new;
	logic [WW-1:0]             col_inc;
	logic [HW-1:0]             row_inc;

	always_comb begin
		gray      = acc_q[lce_pkg::GRAY_SHIFT +: lce_pkg::THR_W];
		hit       = in_band && (gray <= thr_q);
		total_new = total_q + TOT_W'(hit);
		sum_new   = sum_q + (hit ? lce_pkg::SUM_W'(col_q) : '0);
		col_inc   = WW'(col_q) + WW'(1);
		row_inc   = HW'(row_q) + HW'(1);
	end

	// --- divider ---
	logic                      div_start;
	logic [lce_pkg::SUM_W-1:0] quotient;
	lce_pkg::div_stat_t        div_stat;
	logic [lce_pkg::ERR_W-1:0] half_w;
	logic                      out_free;

	assign div_start = (state_q == S_UPD) && px_q.last_in_frame && (total_new != '0);
	assign half_w    = lce_pkg::ERR_W'(w_eff >> 1);
	assign out_free  = !out_valid_q || result.ready;

	lce_div #(.DVS_W(TOT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (total_new),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// --- sequencer ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			px_q        <= '0;
			acc_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			total_q     <= '0;
			sum_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pixel.valid) begin
						px_q    <= pixel.payload;
						step_q  <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					acc_q  <= acc_next;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd2) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (px_q.last_in_frame) begin
						col_q   <= '0;
						row_q   <= '0;
						total_q <= '0;
						sum_q   <= '0;
						if (total_new == '0) begin
							res_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						total_q <= total_new;
						sum_q   <= sum_new;
						state_q <= S_IDLE;
						if (col_inc >= w_eff) begin
							col_q <= '0;
							if (row_inc >= h_eff) begin
								// frame ran past its last row: drop it
								row_q   <= '0;
								total_q <= '0;
								sum_q   <= '0;
							end else begin
								row_q <= row_q + RW'(1);
							end
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						res_q.line_error <= quotient[lce_pkg::ERR_W-1:0] - half_w;
						res_q.line_found <= 1'b1;
						state_q          <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// --- configuration registers ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= lce_pkg::FRAME_WIDTH_RST;
			fh_q  <= lce_pkg::FRAME_HEIGHT_RST;
			thr_q <= lce_pkg::DARK_THRESHOLD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				lce_pkg::REG_FRAME_WIDTH:    fw_q  <= cfg.payload.data;
				lce_pkg::REG_FRAME_HEIGHT:   fh_q  <= cfg.payload.data;
				lce_pkg::REG_DARK_THRESHOLD: thr_q <= cfg.payload.data[lce_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign pixel.ready    = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// --- checks ---
	`ASSERT_NEVER(a_no_accept_while_div, pixel.ready && div_stat.busy, "pixel ready during divide")
	`ASSERT_CLK(a_done_in_div, div_stat.done |-> state_q == S_DIV, "divider done outside divide state")
	`ASSERT_CLK(a_none_is_zero, result.valid && !result.payload.line_found |-> result.payload.line_error == '0, "nonzero error without line")
	`ASSERT_CLK(a_frame_end_clears, state_q == S_UPD && px_q.last_in_frame |=> col_q == '0 && row_q == '0 && total_q == '0, "counters not cleared at frame end")
endmodule

`default_nettype wire
